/* sv/assert_macros.svh */
// Assertion macros for the interpolator RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define SPI_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("spi assertion failed");

// Next-cycle implication, checked outside reset.
`define SPI_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("spi assertion failed");

`endif

/* sv/spi_pkg.sv */
// Shared types and constants of the segment path interpolator.
// No dependencies; used by spi_front, spi_queue, spi_back and the top level.
package spi_pkg;

   localparam int COORD_BITS_DEF  = 32;
   localparam int MAX_DENSITY_DEF = 62;
   localparam int DENS_BITS       = 6;
   localparam int QUEUE_DEPTH     = 2;

   localparam logic REG_PAIR_MODE = 1'b0;
   localparam logic REG_DENSITY   = 1'b1;

   typedef enum logic [1:0] {
      CMD_SEGMENT,
      CMD_POINT,
      CMD_ERROR
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type         kind;
      logic                 also_final;
      logic [DENS_BITS-1:0] density;
   } cmd_ctrl_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_DIV,
      BK_START,
      BK_STEP,
      BK_FINAL,
      BK_ERROR
   } back_state_type;

endpackage

/* sv/spi_channels.sv */
// Valid/ready channel interfaces for waypoints and emitted path points.
// Depends on nothing but the coordinate width parameter.
interface spi_req_if #(parameter int COORD_BITS = 32);
   logic                         valid;
   logic                         ready;
   logic signed [COORD_BITS-1:0] coord_x;
   logic signed [COORD_BITS-1:0] coord_y;
   logic signed [COORD_BITS-1:0] coord_z;
   logic                         final_point;
   modport source (output valid, coord_x, coord_y, coord_z, final_point, input ready);
   modport sink (input valid, coord_x, coord_y, coord_z, final_point, output ready);
endinterface

interface spi_rsp_if #(parameter int COORD_BITS = 32);
   logic                         valid;
   logic                         ready;
   logic signed [COORD_BITS-1:0] out_x;
   logic signed [COORD_BITS-1:0] out_y;
   logic signed [COORD_BITS-1:0] out_z;
   logic                         run_end;
   logic                         odd_count_error;
   modport source (output valid, out_x, out_y, out_z, run_end, odd_count_error,
                   input ready);
   modport sink (input valid, out_x, out_y, out_z, run_end, odd_count_error,
                 output ready);
endinterface

/* sv/spi_front.sv */
// Front end: accepts waypoints, tracks the held point, issues commands.
// Depends on spi_pkg and spi_req_if.
module spi_front #(
   parameter int COORD_BITS  = spi_pkg::COORD_BITS_DEF,
   parameter int MAX_DENSITY = spi_pkg::MAX_DENSITY_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   spi_req_if.sink                              req_ch,
   input  logic                                 pair_mode,
   input  logic [spi_pkg::DENS_BITS-1:0]        density,
   output logic                                 push_valid,
   input  logic                                 push_ready,
   output spi_pkg::cmd_ctrl_type                push_ctrl,
   output logic signed [COORD_BITS-1:0]         start_x,
   output logic signed [COORD_BITS-1:0]         start_y,
   output logic signed [COORD_BITS-1:0]         start_z
);
   logic signed [COORD_BITS-1:0] held_x_ff, held_y_ff, held_z_ff;
   logic signed [COORD_BITS-1:0] held_x_in, held_y_in, held_z_in;
   logic                         holding_ff, holding_in;
   logic [spi_pkg::DENS_BITS-1:0] dens_eff;
   logic                         accept;
   logic                         issue;

   assign req_ch.ready = push_ready;
   assign accept       = req_ch.valid && push_ready;
   assign dens_eff     = (density > spi_pkg::DENS_BITS'(MAX_DENSITY)) ?
                         spi_pkg::DENS_BITS'(MAX_DENSITY) : density;
   assign start_x = held_x_ff;
   assign start_y = held_y_ff;
   assign start_z = held_z_ff;

   always_comb begin
      held_x_in  = held_x_ff;
      held_y_in  = held_y_ff;
      held_z_in  = held_z_ff;
      holding_in = holding_ff;
      issue      = 1'b0;
      push_ctrl.kind       = spi_pkg::CMD_SEGMENT;
      push_ctrl.also_final = 1'b0;
      push_ctrl.density    = dens_eff;
      if (!pair_mode) begin
         if (holding_ff) begin
            issue = 1'b1;
            push_ctrl.also_final = req_ch.final_point;
         end else if (req_ch.final_point) begin
            issue = 1'b1;
            push_ctrl.kind = spi_pkg::CMD_POINT;
         end
         holding_in = !req_ch.final_point;
         if (!req_ch.final_point) begin
            held_x_in = req_ch.coord_x;
            held_y_in = req_ch.coord_y;
            held_z_in = req_ch.coord_z;
         end
      end else begin
         if (holding_ff) begin
            issue      = 1'b1;
            holding_in = 1'b0;
         end else if (req_ch.final_point) begin
            issue = 1'b1;
            push_ctrl.kind = spi_pkg::CMD_ERROR;
         end else begin
            holding_in = 1'b1;
            held_x_in  = req_ch.coord_x;
            held_y_in  = req_ch.coord_y;
            held_z_in  = req_ch.coord_z;
         end
      end
   end

   assign push_valid = accept && issue;

   always_ff @(posedge clock) begin
      if (reset) begin
         holding_ff <= 1'b0;
         held_x_ff  <= '0;
         held_y_ff  <= '0;
         held_z_ff  <= '0;
      end else if (accept) begin
         holding_ff <= holding_in;
         held_x_ff  <= held_x_in;
         held_y_ff  <= held_y_in;
         held_z_ff  <= held_z_in;
      end
   end
endmodule

/* sv/spi_queue.sv */
// Two-entry command queue between the front end and the point generator.
// Depends on spi_pkg for its depth.
module spi_queue #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  logic [WIDTH-1:0] push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output logic [WIDTH-1:0] pop_data
);
   localparam int PTR_BITS = $clog2(spi_pkg::QUEUE_DEPTH);
   localparam int CNT_BITS = $clog2(spi_pkg::QUEUE_DEPTH + 1);

   logic [WIDTH-1:0]    slot_ff [spi_pkg::QUEUE_DEPTH];
   logic [PTR_BITS-1:0] wr_ff, rd_ff;
   logic [CNT_BITS-1:0] count_ff;
   logic                do_push, do_pop;

   assign push_ready = (count_ff != CNT_BITS'(spi_pkg::QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = slot_ff[rd_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         if (do_push) begin
            wr_ff <= (wr_ff == PTR_BITS'(spi_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ff <= (rd_ff == PTR_BITS'(spi_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ff + 1'b1;
         end
         count_ff <= count_ff + CNT_BITS'(do_push) - CNT_BITS'(do_pop);
      end
   end
endmodule

/* sv/spi_back.sv */
// Point generator: per-axis serial divide, then step along the segment; also emits lone final points and error results.
// Depends on spi_pkg, spi_rsp_if and assert_macros.svh.
`include "assert_macros.svh"
module spi_back #(
   parameter int COORD_BITS = spi_pkg::COORD_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         pop_valid,
   output logic                         pop_ready,
   input  spi_pkg::cmd_ctrl_type        pop_ctrl,
   input  logic signed [COORD_BITS-1:0] pop_start [3],
   input  logic signed [COORD_BITS-1:0] pop_end [3],
   spi_rsp_if.source                    rsp_ch
);
   localparam int DB       = spi_pkg::DENS_BITS;
   localparam int DIV_BITS = COORD_BITS + 1;
   localparam int CNT_BITS = $clog2(DIV_BITS + 1);

   spi_pkg::back_state_type state_ff, state_in;
   spi_pkg::cmd_ctrl_type   ctrl_ff;
   logic signed [COORD_BITS-1:0] start_ff [3];
   logic signed [COORD_BITS-1:0] end_ff [3];
   logic [DIV_BITS-1:0]     quo_ff [3], quo_in [3];
   logic [DB:0]             rem_ff [3], rem_in [3];
   logic [DB:0]             accr_ff [3], accr_in [3];
   logic signed [COORD_BITS:0] pos_ff [3], pos_in [3];
   logic                    neg_ff [3];
   logic [CNT_BITS-1:0]     cnt_ff, cnt_in;
   logic [DB-1:0]           step_ff, step_in;
   logic                    out_valid_ff;
   logic signed [COORD_BITS-1:0] out_ff [3], out_in [3];
   logic                    out_end_ff, out_end_in, out_err_ff, out_err_in;
   logic                    emit, slot_free, load;

   assign slot_free       = !out_valid_ff || rsp_ch.ready;
   assign rsp_ch.valid    = out_valid_ff;
   assign rsp_ch.out_x    = out_ff[0];
   assign rsp_ch.out_y    = out_ff[1];
   assign rsp_ch.out_z    = out_ff[2];
   assign rsp_ch.run_end  = out_end_ff;
   assign rsp_ch.odd_count_error = out_err_ff;

   always_comb begin
      logic signed [COORD_BITS:0]   diff;
      logic [DB:0]                  rsh;
      logic [DB:0]                  rsum;
      logic                         carry;
      logic [DIV_BITS-1:0]          stepv;
      logic signed [COORD_BITS+1:0] nxt;
      diff       = '0;
      rsh        = '0;
      rsum       = '0;
      carry      = 1'b0;
      stepv      = '0;
      nxt        = '0;
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      step_in    = step_ff;
      pop_ready  = 1'b0;
      load       = 1'b0;
      emit       = 1'b0;
      out_end_in = 1'b0;
      out_err_in = 1'b0;
      for (int a = 0; a < 3; a++) begin
         quo_in[a]  = quo_ff[a];
         rem_in[a]  = rem_ff[a];
         accr_in[a] = accr_ff[a];
         pos_in[a]  = pos_ff[a];
         out_in[a]  = '0;
      end
      unique case (state_ff)
         spi_pkg::BK_IDLE: begin
            pop_ready = 1'b1;
            if (pop_valid) begin
               load   = 1'b1;
               cnt_in = '0;
               for (int a = 0; a < 3; a++) begin
                  diff = {pop_end[a][COORD_BITS-1], pop_end[a]} -
                         {pop_start[a][COORD_BITS-1], pop_start[a]};
                  quo_in[a] = diff[COORD_BITS] ? DIV_BITS'(-diff) : DIV_BITS'(diff);
                  rem_in[a] = '0;
               end
               unique case (pop_ctrl.kind)
                  spi_pkg::CMD_SEGMENT:
                     state_in = (pop_ctrl.density != '0) ? spi_pkg::BK_DIV : spi_pkg::BK_START;
                  spi_pkg::CMD_POINT: state_in = spi_pkg::BK_FINAL;
                  default:            state_in = spi_pkg::BK_ERROR;
               endcase
            end
         end
         spi_pkg::BK_DIV: begin
            // restoring divide of |end - start| by density, one bit per cycle
            for (int a = 0; a < 3; a++) begin
               rsh = {rem_ff[a][DB-1:0], quo_ff[a][DIV_BITS-1]};
               if (rsh >= {1'b0, ctrl_ff.density}) begin
                  rem_in[a] = rsh - {1'b0, ctrl_ff.density};
                  quo_in[a] = {quo_ff[a][DIV_BITS-2:0], 1'b1};
               end else begin
                  rem_in[a] = rsh;
                  quo_in[a] = {quo_ff[a][DIV_BITS-2:0], 1'b0};
               end
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_BITS'(DIV_BITS - 1)) begin
               state_in = spi_pkg::BK_START;
            end
         end
         spi_pkg::BK_START: begin
            if (slot_free) begin
               emit       = 1'b1;
               out_end_in = (ctrl_ff.density == '0) && !ctrl_ff.also_final;
               step_in    = DB'(1);
               for (int a = 0; a < 3; a++) begin
                  out_in[a]  = start_ff[a];
                  pos_in[a]  = {start_ff[a][COORD_BITS-1], start_ff[a]};
                  accr_in[a] = '0;
               end
               if (ctrl_ff.density != '0) begin
                  state_in = spi_pkg::BK_STEP;
               end else begin
                  state_in = ctrl_ff.also_final ? spi_pkg::BK_FINAL : spi_pkg::BK_IDLE;
               end
            end
         end
         spi_pkg::BK_STEP: begin
            if (slot_free) begin
               emit       = 1'b1;
               out_end_in = (step_ff == ctrl_ff.density) && !ctrl_ff.also_final;
               step_in    = step_ff + 1'b1;
               for (int a = 0; a < 3; a++) begin
                  rsum  = accr_ff[a] + rem_ff[a];
                  carry = (rsum >= {1'b0, ctrl_ff.density});
                  accr_in[a] = carry ? rsum - {1'b0, ctrl_ff.density} : rsum;
                  stepv = quo_ff[a] + DIV_BITS'(carry);
                  nxt   = neg_ff[a] ?
                          {pos_ff[a][COORD_BITS], pos_ff[a]} - {1'b0, stepv} :
                          {pos_ff[a][COORD_BITS], pos_ff[a]} + {1'b0, stepv};
                  pos_in[a] = nxt[COORD_BITS:0];
                  out_in[a] = nxt[COORD_BITS-1:0];
               end
               if (step_ff == ctrl_ff.density) begin
                  state_in = ctrl_ff.also_final ? spi_pkg::BK_FINAL : spi_pkg::BK_IDLE;
               end
            end
         end
         spi_pkg::BK_FINAL: begin
            if (slot_free) begin
               emit       = 1'b1;
               out_end_in = 1'b1;
               for (int a = 0; a < 3; a++) begin
                  out_in[a] = end_ff[a];
               end
               state_in = spi_pkg::BK_IDLE;
            end
         end
         default: begin
            if (slot_free) begin
               emit       = 1'b1;
               out_end_in = 1'b1;
               out_err_in = 1'b1;
               state_in   = spi_pkg::BK_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= spi_pkg::BK_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (emit) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff  <= cnt_in;
      step_ff <= step_in;
      for (int a = 0; a < 3; a++) begin
         quo_ff[a]  <= quo_in[a];
         rem_ff[a]  <= rem_in[a];
         accr_ff[a] <= accr_in[a];
         pos_ff[a]  <= pos_in[a];
      end
      if (load) begin
         ctrl_ff <= pop_ctrl;
         for (int a = 0; a < 3; a++) begin
            start_ff[a] <= pop_start[a];
            end_ff[a]   <= pop_end[a];
            neg_ff[a]   <= (pop_end[a] < pop_start[a]);
         end
      end
      if (emit) begin
         out_end_ff <= out_end_in;
         out_err_ff <= out_err_in;
         for (int a = 0; a < 3; a++) begin
            out_ff[a] <= out_in[a];
         end
      end
   end

   `SPI_ASSERT_NOW(a_div_nonzero, clock, reset, state_ff == spi_pkg::BK_DIV, ctrl_ff.density != '0)
   `SPI_ASSERT_NOW(a_step_bound, clock, reset, state_ff == spi_pkg::BK_STEP, step_ff <= ctrl_ff.density && step_ff != '0)
   `SPI_ASSERT_NEXT(a_err_ends_run, clock, reset, emit && out_err_in, out_end_ff && out_ff[0] == '0 && out_ff[1] == '0 && out_ff[2] == '0)
   `SPI_ASSERT_NEXT(a_pop_only_idle, clock, reset, pop_valid && pop_ready, state_ff != spi_pkg::BK_IDLE)
endmodule

/* sv/segment_path_interpolator.sv */
// Top level of the segment path interpolator: configuration registers and wiring.
// Depends on spi_pkg, spi_channels, spi_front, spi_queue and spi_back.
//
// Waypoints (signed fixed point, Q16.16 at 32 bits) enter on req_ch; path points leave
// on rsp_ch. In chained mode (pair_mode = 0) each waypoint after the first closes a
// segment from the held point, and a waypoint marked final_point is then emitted once
// more on its own; in paired mode waypoints form start/end pairs and a final point
// that opens a pair yields one result with odd_count_error set and zero coordinates.
// A segment gives its start point, then start + trunc(j * (end - start) / D) for
// j = 1..D, D being density clamped to MAX_DENSITY, so the end point lands exactly.
// Flow: the front end takes a waypoint whenever the two-entry command queue has room.
// The back end runs a bit-serial divide of the three axis differences by D, one
// quotient bit per cycle (skipped when D is zero), then emits one point per cycle
// while rsp_ch drains, and takes the next command from the queue only when idle.
// Program csr registers only while no transaction is in flight.

module segment_path_interpolator #(
   parameter int COORD_BITS  = spi_pkg::COORD_BITS_DEF,
   parameter int MAX_DENSITY = spi_pkg::MAX_DENSITY_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   spi_req_if.sink                       req_ch,
   spi_rsp_if.source                     rsp_ch,
   input  logic                          csr_we,
   input  logic                          csr_index,
   input  logic [spi_pkg::DENS_BITS-1:0] csr_wdata
);
   localparam int CTRL_BITS = $bits(spi_pkg::cmd_ctrl_type);
   localparam int QW        = CTRL_BITS + 6 * COORD_BITS;

   // configuration registers
   logic                          pair_mode_ff;
   logic [spi_pkg::DENS_BITS-1:0] density_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pair_mode_ff <= 1'b0;
         density_ff   <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            spi_pkg::REG_PAIR_MODE: pair_mode_ff <= csr_wdata[0];
            default:                density_ff   <= csr_wdata;
         endcase
      end
   end

   // front end to queue
   logic                         push_valid, push_ready;
   spi_pkg::cmd_ctrl_type        push_ctrl;
   logic signed [COORD_BITS-1:0] start_x, start_y, start_z;
   logic [QW-1:0]                push_data, pop_data;
   logic                         pop_valid, pop_ready;
   spi_pkg::cmd_ctrl_type        pop_ctrl;
   logic signed [COORD_BITS-1:0] pop_start [3];
   logic signed [COORD_BITS-1:0] pop_end [3];

   spi_front #(.COORD_BITS(COORD_BITS), .MAX_DENSITY(MAX_DENSITY)) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .pair_mode  (pair_mode_ff),
      .density    (density_ff),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_ctrl  (push_ctrl),
      .start_x    (start_x),
      .start_y    (start_y),
      .start_z    (start_z)
   );

   // pack the command: control, held start point, incoming end point
   assign push_data = {push_ctrl, start_x, start_y, start_z,
                       req_ch.coord_x, req_ch.coord_y, req_ch.coord_z};

   spi_queue #(.WIDTH(QW)) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   // unpack
   assign pop_ctrl     = spi_pkg::cmd_ctrl_type'(pop_data[QW-1 -: CTRL_BITS]);
   assign pop_start[0] = pop_data[6*COORD_BITS-1 -: COORD_BITS];
   assign pop_start[1] = pop_data[5*COORD_BITS-1 -: COORD_BITS];
   assign pop_start[2] = pop_data[4*COORD_BITS-1 -: COORD_BITS];
   assign pop_end[0]   = pop_data[3*COORD_BITS-1 -: COORD_BITS];
   assign pop_end[1]   = pop_data[2*COORD_BITS-1 -: COORD_BITS];
   assign pop_end[2]   = pop_data[COORD_BITS-1 -: COORD_BITS];

   spi_back #(.COORD_BITS(COORD_BITS)) u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_ctrl  (pop_ctrl),
      .pop_start (pop_start),
      .pop_end   (pop_end),
      .rsp_ch    (rsp_ch)
   );
endmodule
